// File: hw/rtl/mer_estimator_unit_assert.svh
// Assertion macros for the MER estimator.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef MER_ESTIMATOR_UNIT_ASSERT_SVH
`define MER_ESTIMATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define MER_AST_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("mer_estimator_unit: same-cycle check failed");
`define MER_AST_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("mer_estimator_unit: next-cycle check failed");
`else
`define MER_AST_IMP(lbl, ant, con)
`define MER_AST_NXT(lbl, ant, con)
`endif

`endif

// File: hw/rtl/mer_pkg.sv
package mer_pkg;

  // defaults for top-level parameters
  localparam int MAX_FRAME_LEN_DEF = 4096;
  localparam int LOG_TBL_DEPTH_DEF = 256;

  // register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_ORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 2'd2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] ALPHA_RST     = 16'd655;
  localparam logic        MOD_ORDER_RST = 1'b1;
  localparam logic [12:0] FRAME_LEN_RST = 13'd64;

  // slicer levels, Q2.13
  localparam int QPSK_LEVEL = 5793;
  localparam int BPSK_LEVEL = 8192;

  // 10*log10(2) in Q.16
  localparam int DB_PER_OCT = 197283;
  localparam logic signed [15:0] MER_SAT = 16'sd32767;

  // shared multiply-accumulate unit geometry
  localparam int MAC_AW = 18;
  localparam int MAC_BW = 32;
  localparam int MAC_PW = MAC_AW + MAC_BW;

  typedef enum logic [1:0] {
    RND_NONE = 2'd0,
    RND_Q16  = 2'd1,
    RND_Q24  = 2'd2
  } rnd_t;

  typedef struct packed {
    logic en;
    logic clr;
    rnd_t rnd;
  } mac_ctl_t;

  typedef struct packed {
    logic        done;
    logic [4:0]  msb;
    logic [15:0] frac;
  } log_sts_t;

  // log2(1 + k/2^kw) in Q.16 by repeated squaring; elaboration only
  function automatic logic [15:0] frac_log2(input int kw, input int k);
    logic [63:0] m;
    logic [15:0] r;
    m = 64'(k + (1 << kw)) << (30 - kw);
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= 64'h0000_0000_8000_0000) begin
        r[b] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/mer_mac.sv
module mer_mac (
  input  logic                       clk,
  input  mer_pkg::mac_ctl_t          ctl,
  input  logic [mer_pkg::MAC_AW-1:0] op_a,
  input  logic [mer_pkg::MAC_BW-1:0] op_b,
  output logic [mer_pkg::MAC_PW-1:0] acc
);

  logic [mer_pkg::MAC_PW-1:0] acc_r;
  logic [mer_pkg::MAC_PW-1:0] acc_nxt;
  logic [mer_pkg::MAC_PW-1:0] base;
  logic [mer_pkg::MAC_PW-1:0] prod;

  always_comb begin
    case (ctl.rnd)
      mer_pkg::RND_Q16: base = mer_pkg::MAC_PW'(1) << 15;
      mer_pkg::RND_Q24: base = mer_pkg::MAC_PW'(1) << 23;
      default:          base = '0;
    endcase
    if (!ctl.clr) begin
      base = acc_r;
    end
    prod    = mer_pkg::MAC_PW'(op_a) * mer_pkg::MAC_PW'(op_b);
    acc_nxt = base + prod;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// File: hw/rtl/mer_log.sv
module mer_log #(
  parameter int TBL_DEPTH = mer_pkg::LOG_TBL_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       avg,
  output mer_pkg::log_sts_t sts
);

  localparam int KW = $clog2(TBL_DEPTH);

  logic [31:0] n_r, n_nxt;
  logic [4:0]  p_r, p_nxt;
  logic        busy_r, busy_nxt;
  logic [15:0] log_tbl [TBL_DEPTH];

  for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_tbl
    assign log_tbl[g] = mer_pkg::frac_log2(KW, g);
  end

  // one-bit-per-cycle normalize: shift until the leading one sits at bit 31
  always_comb begin
    n_nxt    = n_r;
    p_nxt    = p_r;
    busy_nxt = busy_r;
    if (start) begin
      n_nxt    = avg;
      p_nxt    = 5'd31;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r[31]) begin
        busy_nxt = 1'b0;
      end else begin
        n_nxt = {n_r[30:0], 1'b0};
        p_nxt = p_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    p_r <= p_nxt;
  end

  assign sts.done = busy_r & n_r[31];
  assign sts.msb  = p_r;
  assign sts.frac = log_tbl[n_r[30 -: KW]];

endmodule

// File: hw/rtl/mer_estimator_unit.sv
// MER estimator: slice, squared error, exponential average, dB at frame end.
// One sample at a time: the shared 18x32 multiply-accumulate unit runs five
// sequencer steps after the transfer while the input stalls. Frame-end sample:
// NORM (leading-one search of the average), SCALE, then ROUND loads the result
// register once the output is free; a zero average goes straight to ROUND.
// Reset (rst_n low, synchronous): defaults, average and count cleared.
`include "mer_estimator_unit_assert.svh"

module mer_estimator_unit #(
  parameter int MAX_FRAME_LEN   = mer_pkg::MAX_FRAME_LEN_DEF,
  parameter int LOG_TABLE_DEPTH = mer_pkg::LOG_TBL_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             in_i_sample,
  input  logic signed [15:0]             in_q_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             out_mer_db,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mer_pkg::CFG_DATA_W-1:0] cfg_data
);

  // frame counter widths: position stays below the max length, position+1 reaches it
  localparam int PW   = (MAX_FRAME_LEN > 1) ? $clog2(MAX_FRAME_LEN) : 1;
  localparam int LW_M = $clog2(MAX_FRAME_LEN + 1);
  localparam int LW   = (LW_M > 13) ? LW_M : 13;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_SQI   = 9'b0_0000_0010,  // |ei|^2
    ST_SQQ   = 9'b0_0000_0100,  // + |eq|^2
    ST_UPD1  = 9'b0_0000_1000,  // (1-alpha)*avg + round
    ST_UPD2  = 9'b0_0001_0000,  // + alpha*err
    ST_AVG   = 9'b0_0010_0000,  // write back average, decide on result
    ST_NORM  = 9'b0_0100_0000,  // leading-one search and table lookup
    ST_SCALE = 9'b0_1000_0000,  // octaves times dB per octave
    ST_ROUND = 9'b1_0000_0000   // load result register
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] alpha_r;
  logic        mod_r;
  logic [12:0] flen_r;

  // datapath registers
  logic [31:0]   avg_r, avg_nxt;
  logic [PW-1:0] pos_r;
  logic          last_r;
  logic [15:0]   emi_r, emq_r;
  logic [29:0]   err_r;
  logic [20:0]   dmag_r;
  logic          neg_r;
  logic          sat_r;
  logic          out_valid_r;
  logic signed [15:0] mer_r;

  logic in_xfer, cfg_xfer, out_free;

  assign in_xfer  = in_valid & ~in_stall;
  assign cfg_xfer = cfg_valid & cfg_ready;
  assign out_free = ~out_valid_r | ~out_stall;

  // a pending register write goes first; the sample is stalled while cfg_valid is high
  assign in_stall  = (state_r != ST_IDLE) | cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_mer_db = mer_r;

  // ---------------------------------------------------------------
  // Slicer: nearest point, ties at zero go positive. Error magnitudes
  // are at most 32768, so 16 unsigned bits hold them.
  // ---------------------------------------------------------------
  logic signed [17:0] si_x, sq_x, ideal_i, ideal_q, ei, eq;
  logic [17:0] ei_abs, eq_abs;

  always_comb begin
    si_x = 18'(in_i_sample);
    sq_x = 18'(in_q_sample);
    if (mod_r) begin
      ideal_i = in_i_sample[15] ? -18'(mer_pkg::QPSK_LEVEL) : 18'(mer_pkg::QPSK_LEVEL);
      ideal_q = in_q_sample[15] ? -18'(mer_pkg::QPSK_LEVEL) : 18'(mer_pkg::QPSK_LEVEL);
    end else begin
      ideal_i = in_i_sample[15] ? -18'(mer_pkg::BPSK_LEVEL) : 18'(mer_pkg::BPSK_LEVEL);
      ideal_q = '0;
    end
    ei     = ideal_i - si_x;
    eq     = ideal_q - sq_x;
    ei_abs = ei[17] ? 18'(-ei) : 18'(ei);
    eq_abs = eq[17] ? 18'(-eq) : 18'(eq);
  end

  // frame end: length 0 counts as 1, above the max clamps to the max
  logic [LW-1:0] len_eff, pos_inc;
  logic          last_now;

  always_comb begin
    len_eff = LW'(flen_r);
    if (len_eff == '0) begin
      len_eff = LW'(1);
    end else if (len_eff > LW'(MAX_FRAME_LEN)) begin
      len_eff = LW'(MAX_FRAME_LEN);
    end
    pos_inc  = LW'(pos_r) + LW'(1);
    last_now = (pos_inc >= len_eff);
  end

  // ---------------------------------------------------------------
  // Shared multiply-accumulate unit
  // ---------------------------------------------------------------
  mer_pkg::mac_ctl_t          mac_ctl;
  logic [mer_pkg::MAC_AW-1:0] mac_a;
  logic [mer_pkg::MAC_BW-1:0] mac_b;
  logic [mer_pkg::MAC_PW-1:0] acc_r;

  always_comb begin
    mac_ctl.en  = 1'b0;
    mac_ctl.clr = 1'b0;
    mac_ctl.rnd = mer_pkg::RND_NONE;
    mac_a       = '0;
    mac_b       = '0;
    case (state_r)
      ST_SQI: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        mac_a       = mer_pkg::MAC_AW'(emi_r);
        mac_b       = mer_pkg::MAC_BW'(emi_r);
      end
      ST_SQQ: begin
        mac_ctl.en = 1'b1;
        mac_a      = mer_pkg::MAC_AW'(emq_r);
        mac_b      = mer_pkg::MAC_BW'(emq_r);
      end
      ST_UPD1: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        mac_ctl.rnd = mer_pkg::RND_Q16;
        mac_a       = mer_pkg::MAC_AW'(17'h1_0000 - {1'b0, alpha_r});
        mac_b       = avg_r;
      end
      ST_UPD2: begin
        mac_ctl.en = 1'b1;
        mac_a      = mer_pkg::MAC_AW'(alpha_r);
        mac_b      = mer_pkg::MAC_BW'(err_r);
      end
      ST_SCALE: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        mac_ctl.rnd = mer_pkg::RND_Q24;
        mac_a       = mer_pkg::MAC_AW'(mer_pkg::DB_PER_OCT);
        mac_b       = mer_pkg::MAC_BW'(dmag_r);
      end
      default: begin
        mac_ctl.en = 1'b0;
      end
    endcase
  end

  mer_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc_r)
  );

  // new average: accumulator >> 16, clamped to 32 bits
  logic [33:0] avg_wide;
  assign avg_wide = acc_r[49:16];
  assign avg_nxt  = (|avg_wide[33:32]) ? '1 : avg_wide[31:0];

  // ---------------------------------------------------------------
  // Logarithm: leading-one search plus fraction table
  // ---------------------------------------------------------------
  logic              log_start;
  mer_pkg::log_sts_t log_sts;

  assign log_start = (state_r == ST_AVG) && last_r && (avg_nxt != '0);

  mer_log #(
    .TBL_DEPTH (LOG_TABLE_DEPTH)
  ) u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .avg   (avg_nxt),
    .sts   (log_sts)
  );

  // octaves below 2^-24 scale: (24 << 16) - log2(avg), Q.16
  logic [20:0]        lg;
  logic signed [22:0] dq;
  assign lg = {log_sts.msb, log_sts.frac};
  assign dq = 23'sd1572864 - signed'({2'b00, lg});

  // rounded dB magnitude, Q8.8
  logic [15:0]        mag;
  logic signed [15:0] mer_val;
  assign mag     = acc_r[39:24];
  assign mer_val = sat_r ? mer_pkg::MER_SAT : (neg_r ? signed'(-mag) : signed'(mag));

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SQI;
        end
      end
      ST_SQI:  state_nxt = ST_SQQ;
      ST_SQQ:  state_nxt = ST_UPD1;
      ST_UPD1: state_nxt = ST_UPD2;
      ST_UPD2: state_nxt = ST_AVG;
      ST_AVG: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (avg_nxt == '0) begin
          state_nxt = ST_ROUND;
        end else begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (log_sts.done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alpha_r     <= mer_pkg::ALPHA_RST;
      mod_r       <= mer_pkg::MOD_ORDER_RST;
      flen_r      <= mer_pkg::FRAME_LEN_RST;
      avg_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_AVG) begin
        avg_r <= avg_nxt;
      end
      if (in_xfer) begin
        pos_r <= last_now ? '0 : pos_inc[PW-1:0];
      end
      if (cfg_xfer) begin
        case (cfg_index)
          mer_pkg::REG_ALPHA: begin
            alpha_r <= cfg_data;
            avg_r   <= '0;
          end
          mer_pkg::REG_MOD_ORDER: mod_r  <= cfg_data[0];
          mer_pkg::REG_FRAME_LEN: flen_r <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (state_r == ST_ROUND && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      emi_r  <= ei_abs[15:0];
      emq_r  <= eq_abs[15:0];
      last_r <= last_now;
    end
    if (state_r == ST_UPD1) begin
      err_r <= acc_r[31:2];
    end
    if (state_r == ST_AVG) begin
      sat_r <= (avg_nxt == '0);
    end
    if (state_r == ST_NORM && log_sts.done) begin
      neg_r  <= dq[22];
      dmag_r <= dq[22] ? 21'(-dq) : 21'(dq);
    end
    if (state_r == ST_ROUND && out_free) begin
      mer_r <= mer_val;
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `MER_AST_IMP(a_pos_range, 1'b1, LW'(pos_r) < LW'(MAX_FRAME_LEN))
  `MER_AST_IMP(a_norm_nonzero, state_r == ST_NORM, avg_r != '0)
  `MER_AST_IMP(a_db_fits, (state_r == ST_ROUND) && !sat_r, acc_r[49:39] == '0)
  `MER_AST_NXT(a_avg_bound, state_r == ST_AVG,
               (avg_r <= $past(avg_r)) || (avg_r <= {2'b00, err_r}))

endmodule
